// ----- rtl/bresenham_line_rasterizer_top_macros.svh -----
// Assertion macros for the line rasterizer checker.
// Plain text macros only; no dependencies.
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BRL_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define BRL_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/brl_pkg.sv -----
// Shared constants and controller/datapath interface types for the line rasterizer.
// No dependencies.
`default_nettype none

package brl_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int FIELD_W        = 6;
    localparam int COLOR_W        = 24;
    // start_x, start_y, end_x, end_y, line_color
    localparam int S_TDATA_W      = 4 * FIELD_W + COLOR_W;
    // pixel_x, pixel_y, pixel_color, padded to whole bytes
    localparam int M_PAYLOAD_W    = 2 * FIELD_W + COLOR_W;
    localparam int M_TDATA_W      = ((M_PAYLOAD_W + 7) / 8) * 8;

    typedef struct packed {
        logic load;   // capture a new request
        logic step;   // advance to the next pixel
    } brl_cmd_t;

    typedef struct packed {
        logic last;   // current pixel is the final one
    } brl_stat_t;

endpackage

`default_nettype wire

// ----- rtl/brl_ctrl.sv -----
// Controller FSM of the line rasterizer: handshakes and datapath commands.
// Depends on brl_pkg.
`default_nettype none

module brl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire brl_pkg::brl_stat_t stat,
    output brl_pkg::brl_cmd_t      cmd
);
    import brl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (stat.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/brl_datapath.sv -----
// Datapath of the line rasterizer: endpoint setup, error term and one step per pixel.
// Depends on brl_pkg.
`default_nettype none

module brl_datapath #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic [brl_pkg::S_TDATA_W-1:0] req_data,
    input  wire brl_pkg::brl_cmd_t             cmd,
    output brl_pkg::brl_stat_t                 stat,
    output logic [brl_pkg::M_TDATA_W-1:0]      pix_data
);
    import brl_pkg::*;

    localparam int ERR_W = COORD_BITS + 2;
    localparam int E2_W  = COORD_BITS + 3;

    logic [COORD_BITS-1:0]   x_reg, y_reg, xe_reg, ye_reg, dx_reg, dy_reg, cnt_reg;
    logic [COORD_BITS-1:0]   x_next, y_next, xe_next, ye_next, dx_next, dy_next, cnt_next;
    logic                    sx_reg, sy_reg, sx_next, sy_next;   // 1 = increment
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [COLOR_W-1:0]      color_reg, color_next;

    // request decode, only the low COORD_BITS of each coordinate count
    logic [COORD_BITS-1:0]   in_x, in_y, in_xe, in_ye, in_dx, in_dy;
    logic                    in_sx, in_sy;
    logic signed [ERR_W-1:0] in_err;

    assign in_x  = req_data[0 +: COORD_BITS];
    assign in_y  = req_data[FIELD_W +: COORD_BITS];
    assign in_xe = req_data[2 * FIELD_W +: COORD_BITS];
    assign in_ye = req_data[3 * FIELD_W +: COORD_BITS];
    assign in_sx = in_x < in_xe;
    assign in_sy = in_y < in_ye;
    assign in_dx = in_sx ? in_xe - in_x : in_x - in_xe;
    assign in_dy = in_sy ? in_ye - in_y : in_y - in_ye;
    assign in_err = $signed(ERR_W'(in_dx)) - $signed(ERR_W'(in_dy));

    // one Bresenham step; both tests use the same doubled error
    logic signed [E2_W-1:0] e2, err_ext, dx_ext, dy_ext, err_sum;
    logic                   step_x, step_y;

    assign err_ext = E2_W'(err_reg);
    assign e2      = err_ext <<< 1;
    assign dx_ext  = $signed(E2_W'(dx_reg));
    assign dy_ext  = $signed(E2_W'(dy_reg));
    assign step_x  = e2 > -dy_ext;
    assign step_y  = e2 < dx_ext;
    assign err_sum = err_ext - (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0);

    always_comb begin
        x_next     = x_reg;
        y_next     = y_reg;
        xe_next    = xe_reg;
        ye_next    = ye_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        err_next   = err_reg;
        color_next = color_reg;
        cnt_next   = cnt_reg;
        if (cmd.load) begin
            x_next     = in_x;
            y_next     = in_y;
            xe_next    = in_xe;
            ye_next    = in_ye;
            dx_next    = in_dx;
            dy_next    = in_dy;
            sx_next    = in_sx;
            sy_next    = in_sy;
            err_next   = in_err;
            color_next = req_data[4 * FIELD_W +: COLOR_W];
            cnt_next   = '0;
        end else if (cmd.step) begin
            if (step_x) begin
                x_next = sx_reg ? x_reg + 1'b1 : x_reg - 1'b1;
            end
            if (step_y) begin
                y_next = sy_reg ? y_reg + 1'b1 : y_reg - 1'b1;
            end
            err_next = err_sum[ERR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        xe_reg    <= xe_next;
        ye_reg    <= ye_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        err_reg   <= err_next;
        color_reg <= color_next;
        cnt_reg   <= cnt_next;
    end

    // endpoint reached, or pixel budget of the coordinate range used up
    assign stat.last = ((x_reg == xe_reg) && (y_reg == ye_reg)) || (&cnt_reg);

    assign pix_data = M_TDATA_W'({color_reg, FIELD_W'(y_reg), FIELD_W'(x_reg)});

endmodule

`default_nettype wire

// ----- rtl/bresenham_line_rasterizer_top.sv -----
// Latency: first pixel word is valid the cycle after a request word is accepted.
// Throughput: one pixel per cycle while m_tready is high; a line of L pixels
// (L = max(|dx|,|dy|)+1, at most 2^COORD_BITS) comes from the single stepping unit,
// and no new request is accepted until the last pixel of the line has been taken.
// Reset: synchronous active-low aresetn returns the controller to idle.
// Depends on brl_pkg, brl_ctrl, brl_datapath.
`default_nettype none

module bresenham_line_rasterizer_top #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // start_x, start_y, end_x, end_y, line_color (low bits first)
    input  wire logic [brl_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad (low bits first)
    output logic [brl_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast   // last_pixel
);
    import brl_pkg::*;

    brl_cmd_t  cmd;
    brl_stat_t stat;

    brl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brl_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk     (aclk),
        .req_data (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .pix_data (m_tdata)
    );

    assign m_tlast = stat.last;

endmodule

`default_nettype wire

// ----- rtl/brl_checker.sv -----
// Port-level checker for the line rasterizer, bound to the top level.
// Depends on brl_pkg and bresenham_line_rasterizer_top_macros.svh.
`default_nettype none
`include "bresenham_line_rasterizer_top_macros.svh"

module brl_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [brl_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);
    import brl_pkg::*;

    // a stalled pixel word holds
    `BRL_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled pixel word changed")
    // one request at a time: no new request while pixels are pending
    `BRL_NEVER(a_one_line, aclk, aresetn, s_tready && m_tvalid, "request taken during a line")
    // an accepted request yields a pixel on the next cycle
    `BRL_ASSERT(a_req_to_pix, aclk, aresetn, s_tvalid && s_tready |=> m_tvalid, "no pixel after request")
    // the line ends with its marked pixel
    `BRL_ASSERT(a_last_ends, aclk, aresetn, m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready, "pixels continue after last")

endmodule

bind bresenham_line_rasterizer_top brl_checker u_brl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the Bresenham line rasterizer top level.
// Needs brl_pkg and bresenham_line_rasterizer_top; predicts each pixel word and
// compares it against the stream coming out of the block.
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [5:0]  x;
        logic [5:0]  y;
        logic [23:0] color;
        logic        last;
    } pixel_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // start_x, start_y, end_x, end_y, line_color (low bits first)
    logic [brl_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // pixel_x, pixel_y, pixel_color, zero pad (low bits first)
    logic [brl_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    pixel_t pending_pixels[$];
    pixel_t want;
    int     lines_sent     = 0;
    int     pixels_checked = 0;
    int     mismatches     = 0;
    int     hold_request   = 0;
    int     rx_hold        = 0;
    bit     quiet          = 1'b0;   // no random idling on either side while set

    bresenham_line_rasterizer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("%0t: watchdog expired, %0d pixel words still outstanding",
                 $time, pending_pixels.size());
        $display("[bresenham_line_rasterizer_top] ERROR");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Walks the line exactly as the block should and queues every pixel.
    function automatic void plot_line(input logic [5:0] x0, input logic [5:0] y0,
                                      input logic [5:0] x1, input logic [5:0] y1,
                                      input logic [23:0] color);
        int     x, y, xe, ye, dx, dy, sx, sy, err, e2, count;
        bit     fin;
        pixel_t p;
        x     = int'(x0);
        y     = int'(y0);
        xe    = int'(x1);
        ye    = int'(y1);
        dx    = (xe > x) ? xe - x : x - xe;
        dy    = (ye > y) ? ye - y : y - ye;
        sx    = (x < xe) ? 1 : -1;
        sy    = (y < ye) ? 1 : -1;
        err   = dx - dy;
        count = 0;
        do begin
            fin     = ((x == xe) && (y == ye)) || (count == 63);
            p.x     = x[5:0];
            p.y     = y[5:0];
            p.color = color;
            p.last  = fin;
            pending_pixels.push_back(p);
            count++;
            if (!fin) begin
                e2 = 2 * err;
                if (e2 > -dy) begin
                    err -= dy;
                    x   += sx;
                end
                if (e2 < dx) begin
                    err += dx;
                    y   += sy;
                end
            end
        end while (!fin);
    endfunction

    // Offers one request word and returns once it has been taken.
    task automatic send_line(input logic [5:0] x0, input logic [5:0] y0,
                             input logic [5:0] x1, input logic [5:0] y1,
                             input logic [23:0] color);
        int gap;
        s_tdata  <= {color, y1, x1, y0, x0};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        plot_line(x0, y0, x1, y1, color);
        lines_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic stop_stream();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [5:0] near(input logic [5:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 14)) - 7;
        if (v < 0)
            v = 0;
        if (v > 63)
            v = 63;
        return v[5:0];
    endfunction

    task automatic random_line();
        logic [5:0]  x0, y0, x1, y1;
        logic [23:0] color;
        int          kind;
        x0    = 6'($urandom_range(0, 63));
        y0    = 6'($urandom_range(0, 63));
        x1    = 6'($urandom_range(0, 63));
        y1    = 6'($urandom_range(0, 63));
        color = 24'($urandom());
        kind  = $urandom_range(0, 9);
        if (kind < 5) begin
            // short lines keep the run fast
            x1 = near(x0);
            y1 = near(y0);
        end else if (kind == 5) begin
            y1 = y0;
        end else if (kind == 6) begin
            x1 = x0;
        end else if (kind == 7) begin
            x1 = x0;
            y1 = y0;
        end
        send_line(x0, y0, x1, y1, color);
    endtask

    // Receiver: random back-pressure, plus a long hold when a test asks for one.
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            rx_hold      = hold_request;
            hold_request = 0;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) < 70)
                        || ($urandom_range(0, 99) < 50 && m_tready);
            if (!quiet && $urandom_range(0, 99) < 3)
                rx_hold = $urandom_range(10, 40);
        end
    end

    // Pixel word checker.
    always @(posedge aclk) begin : check_pixels
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: pixel word with nothing expected: x=%0d y=%0d color=%06h last=%0b",
                         $time, m_tdata[5:0], m_tdata[11:6], m_tdata[35:12], m_tlast);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (m_tdata[5:0] !== want.x) begin
                    $display("%0t: pixel_x expected %0d got %0d", $time, want.x, m_tdata[5:0]);
                    mismatches++;
                end
                if (m_tdata[11:6] !== want.y) begin
                    $display("%0t: pixel_y expected %0d got %0d", $time, want.y, m_tdata[11:6]);
                    mismatches++;
                end
                if (m_tdata[35:12] !== want.color) begin
                    $display("%0t: pixel_color expected %06h got %06h",
                             $time, want.color, m_tdata[35:12]);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_pixel expected %0b got %0b", $time, want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Endpoints at the edges, every octant, both axes, all four diagonals.
    task automatic test_directed();
        send_line(6'd0,  6'd0,  6'd0,  6'd0,  24'h000000);
        send_line(6'd63, 6'd63, 6'd63, 6'd63, 24'hFFFFFF);
        send_line(6'd0,  6'd0,  6'd63, 6'd0,  24'hAA5555);
        send_line(6'd63, 6'd5,  6'd0,  6'd5,  24'h55AAAA);
        send_line(6'd7,  6'd0,  6'd7,  6'd63, 24'h800001);
        send_line(6'd9,  6'd63, 6'd9,  6'd0,  24'h7FFFFE);
        send_line(6'd0,  6'd0,  6'd63, 6'd63, 24'hFF0000);
        send_line(6'd63, 6'd63, 6'd0,  6'd0,  24'h00FF00);
        send_line(6'd0,  6'd63, 6'd63, 6'd0,  24'h0000FF);
        send_line(6'd63, 6'd0,  6'd0,  6'd63, 24'h123456);
        send_line(6'd10, 6'd10, 6'd30, 6'd17, 24'h654321);
        send_line(6'd10, 6'd10, 6'd17, 6'd30, 24'hC3C3C3);
        send_line(6'd30, 6'd10, 6'd10, 6'd17, 24'h3C3C3C);
        send_line(6'd17, 6'd10, 6'd10, 6'd30, 24'hF0F0F0);
        send_line(6'd30, 6'd30, 6'd10, 6'd23, 24'h0F0F0F);
        send_line(6'd17, 6'd30, 6'd10, 6'd10, 24'hDEADBE);
        send_line(6'd10, 6'd30, 6'd30, 6'd23, 24'hEF0001);
        send_line(6'd10, 6'd30, 6'd17, 6'd10, 24'h010203);
        send_line(6'd0,  6'd0,  6'd1,  6'd1,  24'hFFFFFF);
        send_line(6'd5,  6'd5,  6'd6,  6'd5,  24'h000000);
        send_line(6'd32, 6'd32, 6'd31, 6'd33, 24'h5A5A5A);
        send_line(6'd0,  6'd1,  6'd63, 6'd62, 24'hA5A5A5);
        stop_stream();
    endtask

    task automatic test_random(input int n);
        repeat (n) random_line();
        stop_stream();
    endtask

    // A stretch with neither side idling.
    task automatic test_back_to_back(input int n);
        quiet = 1'b1;
        repeat (n) random_line();
        stop_stream();
        quiet = 1'b0;
    endtask

    // Receiver stops for a long while; requests keep coming until input stalls.
    task automatic test_backpressure();
        quiet        = 1'b1;
        hold_request = 400;
        repeat (8)
            send_line(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      24'($urandom()));
        stop_stream();
        quiet = 1'b0;
    endtask

    initial begin
        int waited;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(80);
        test_backpressure();
        test_back_to_back(20);
        test_random(80);

        waited = 0;
        while (pending_pixels.size() != 0 && waited < 100_000) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_pixels.size() != 0) begin
            $display("%0t: %0d expected pixel words never arrived",
                     $time, pending_pixels.size());
            mismatches++;
        end
        // wait for any stray word
        repeat (80) @(posedge aclk);

        $display("Covered %0d line requests (edges, all octants, zero length, stalls):",
                 lines_sent);
        $display("  %0d pixel words compared, %0d mismatches", pixels_checked, mismatches);
        if (mismatches == 0)
            $display("[bresenham_line_rasterizer_top] OK");
        else
            $display("[bresenham_line_rasterizer_top] ERROR");
        $finish;
    end

endmodule
